// ===== rtl/core/lmdfb_pkg.sv =====
// shared types, constants and font rom for the led matrix frame buffer
// no dependencies; imported by the frame buffer top level and its checker
package lmdfb_pkg;

  localparam int LedCount  = 64;
  localparam int IdxW      = $clog2(LedCount);
  localparam int ColorW    = 24;
  localparam int MaxNumber = 99;
  localparam int Radix     = 10;
  localparam int LastCol   = 7;

  // tens digit of a value up to 99 as (n * RecipMul) >> RecipShift
  localparam int RecipMul   = 205;
  localparam int RecipShift = 11;

  localparam int SDataW = 72;
  localparam int SUserW = 3;
  localparam int MDataW = 32;
  localparam int MUserW = 1;

  // digit code that draws nothing
  localparam logic [3:0] DigitNone = 4'hF;

  typedef enum logic [2:0] {
    KindSetXy   = 3'd0,
    KindSetIdx  = 3'd1,
    KindClear   = 3'd2,
    KindUpdate  = 3'd3,
    KindShowNum = 3'd4,
    KindShowTwo = 3'd5
  } kind_e;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StSetWr = 6'b000010,
    StClear = 6'b000100,
    StShow  = 6'b001000,
    StScan  = 6'b010000,
    StLatch = 6'b100000
  } state_e;

  typedef logic [ColorW-1:0] color_t;
  typedef logic [IdxW-1:0]   led_idx_t;

  // one 4-pixel font row, bit 3 is the leftmost column; blank for codes above 9
  function automatic logic [3:0] font_row(input logic [3:0] digit, input logic [2:0] r);
    logic [31:0] glyph;
    unique case (digit)
      4'd0:    glyph = 32'hF999999F;
      4'd1:    glyph = 32'hF2222A62;
      4'd2:    glyph = 32'hF888F11F;
      4'd3:    glyph = 32'hF111F11F;
      4'd4:    glyph = 32'h1111F999;
      4'd5:    glyph = 32'hF111F88F;
      4'd6:    glyph = 32'hF999F88F;
      4'd7:    glyph = 32'h1111111F;
      4'd8:    glyph = 32'hF999F99F;
      4'd9:    glyph = 32'hF111F99F;
      default: glyph = 32'h00000000;
    endcase
    return glyph[{r, 2'b00} +: 4];
  endfunction

  // serpentine wiring: even rows run right to left
  function automatic led_idx_t grid_index(input logic [2:0] col, input logic [2:0] row);
    logic [2:0] c;
    c = row[0] ? col : 3'(LastCol) - col;
    return {row, c};
  endfunction

endpackage

// ===== rtl/core/lmdfb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; holds the led color store of the frame buffer
module lmdfb_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/led_matrix_dirty_frame_buffer.sv =====
// frame buffer for an 8x8 serpentine led matrix with per-led dirty tracking
// depends on lmdfb_pkg and lmdfb_ram
//
// usage: commands arrive as beats on the s_axis side (kind in tuser, operands
// in tdata). set and clear commands change the store and emit nothing. update
// walks the leds in strip order and emits one m_axis beat per dirty led
// (tuser = 1, tdata = index and color); tlast marks the last beat of a run.
// with nothing dirty but a refresh still pending, a single beat with tuser 0,
// zero data and tlast set is emitted. show commands blank the matrix, draw the
// digits and then run an update.
// timing: one command at a time, s_axis_tready is high only while idle.
// set: one compare and a conditional write. clear: one pass over all leds. update:
// one led per cycle while the output is free, from index 0 up to the last dirty led.
// show: a redraw pass over all leds, then the update scan. the shared store
// port takes one led per cycle in each pass; a waiting beat can stall the scan.
// stall: while m_axis_tready is low, the scan holds on the pending led; the
// result register lets the next command beat be taken while a beat waits.
// reset: store reads as zero (per-led valid bits), no led dirty, refresh pending.
module led_matrix_dirty_frame_buffer
  import lmdfb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // col[2:0], row[5:3], led_index[11:6], color_a[35:12], color_b[59:36],
  // number_a[66:60], number_b[70:67], zero[71]
  input  logic [SDataW-1:0] s_axis_tdata,
  // kind[2:0]
  input  logic [SUserW-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_index[5:0], out_color[29:6], zero[31:30]
  output logic [MDataW-1:0] m_axis_tdata,
  // has_pixel[0]
  output logic [MUserW-1:0] m_axis_tuser,
  // latch_frame
  output logic              m_axis_tlast
);

  // command fields
  logic [2:0]  in_col, in_row;
  led_idx_t    in_led_index;
  color_t      in_color_a, in_color_b;
  logic [6:0]  in_number_a;
  logic [3:0]  in_number_b;

  assign in_col       = s_axis_tdata[2:0];
  assign in_row       = s_axis_tdata[5:3];
  assign in_led_index = s_axis_tdata[11:6];
  assign in_color_a   = s_axis_tdata[35:12];
  assign in_color_b   = s_axis_tdata[59:36];
  assign in_number_a  = s_axis_tdata[66:60];
  assign in_number_b  = s_axis_tdata[70:67];

  state_e state_q, state_d;
  led_idx_t ptr_q, ptr_d;
  logic [LedCount-1:0] dirty_q, dirty_d;
  logic [LedCount-1:0] valid_q, valid_d;
  logic pending_q, pending_d;

  color_t color_l_q, color_l_d, color_r_q, color_r_d;
  logic [3:0] dig_l_q, dig_l_d, dig_r_q, dig_r_d;
  logic center_q, center_d;

  logic     m_valid_q, m_valid_d;
  logic     has_pixel_q, has_pixel_d;
  led_idx_t out_index_q, out_index_d;
  color_t   out_color_q, out_color_d;
  logic     latch_q, latch_d;

  logic     ram_we;
  color_t   ram_wdata;
  color_t   ram_rdata;
  color_t   old_color;
  logic     out_free;

  lmdfb_ram #(
    .Width(ColorW),
    .Depth(LedCount)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i(ram_wdata),
    .re_i   (1'b1),
    .raddr_i(ptr_d),
    .rdata_o(ram_rdata)
  );

  // the read data always belongs to ptr_q; a never-written led reads as zero
  assign old_color = valid_q[ptr_q] ? ram_rdata : '0;
  assign out_free  = !m_valid_q || m_axis_tready;

  // tens and ones of number_a by reciprocal multiply
  logic [14:0] tens_prod;
  logic [3:0]  tens_dig, ones_dig;
  assign tens_prod = 15'(in_number_a) * 15'(RecipMul);
  assign tens_dig  = tens_prod[14:RecipShift];
  assign ones_dig  = 4'(in_number_a - 7'(tens_dig) * 7'(Radix));

  // pixel under ptr_q for the redraw pass
  logic [2:0] pix_row, pix_col, pix_off;
  logic [1:0] font_col;
  logic [3:0] pix_dig, pix_font;
  logic       pix_in_range, pix_lit;
  color_t     pix_color, pix_new;

  always_comb begin
    pix_row = ptr_q[5:3];
    pix_col = pix_row[0] ? ptr_q[2:0] : 3'(LastCol) - ptr_q[2:0];
    pix_off = pix_col - 3'd2;
    if (center_q) begin
      pix_in_range = (pix_col >= 3'd2) && (pix_col <= 3'd5);
      font_col     = pix_off[1:0];
      pix_dig      = dig_l_q;
      pix_color    = color_l_q;
    end else begin
      pix_in_range = 1'b1;
      font_col     = pix_col[1:0];
      pix_dig      = pix_col[2] ? dig_r_q : dig_l_q;
      pix_color    = pix_col[2] ? color_r_q : color_l_q;
    end
    pix_font = font_row(pix_dig, pix_row);
    pix_lit  = pix_in_range && pix_font[2'd3 - font_col];
    pix_new  = pix_lit ? pix_color : '0;
  end

  // no dirty led above ptr_q: this beat closes the run
  logic [LedCount-1:0] dirty_above;
  logic                last_dirty;
  assign dirty_above = dirty_q >> ptr_q;
  assign last_dirty  = (dirty_above[LedCount-1:1] == '0);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    dirty_d     = dirty_q;
    valid_d     = valid_q;
    pending_d   = pending_q;
    color_l_d   = color_l_q;
    color_r_d   = color_r_q;
    dig_l_d     = dig_l_q;
    dig_r_d     = dig_r_q;
    center_d    = center_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    has_pixel_d = has_pixel_q;
    out_index_d = out_index_q;
    out_color_d = out_color_q;
    latch_d     = latch_q;
    ram_we      = 1'b0;
    ram_wdata   = '0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          color_l_d = in_color_a;
          color_r_d = in_color_b;
          center_d  = 1'b0;
          unique case (kind_e'(s_axis_tuser))
            KindSetXy: begin
              ptr_d   = grid_index(in_col, in_row);
              state_d = StSetWr;
            end
            KindSetIdx: begin
              ptr_d   = in_led_index;
              state_d = StSetWr;
            end
            KindClear: begin
              ptr_d   = '0;
              state_d = StClear;
            end
            KindUpdate: begin
              ptr_d = '0;
              if (dirty_q != '0) begin
                state_d = StScan;
              end else if (pending_q) begin
                state_d = StLatch;
              end
            end
            KindShowNum: begin
              ptr_d     = '0;
              state_d   = StShow;
              color_r_d = in_color_a;
              if (in_number_a > 7'(MaxNumber)) begin
                dig_l_d = DigitNone;
                dig_r_d = DigitNone;
              end else if (in_number_a < 7'(Radix)) begin
                dig_l_d  = in_number_a[3:0];
                dig_r_d  = DigitNone;
                center_d = 1'b1;
              end else begin
                dig_l_d = tens_dig;
                dig_r_d = ones_dig;
              end
            end
            KindShowTwo: begin
              ptr_d   = '0;
              state_d = StShow;
              dig_l_d = (in_number_a < 7'(Radix)) ? in_number_a[3:0] : DigitNone;
              dig_r_d = in_number_b;
            end
            default: begin
              // unused kinds are dropped
            end
          endcase
        end
      end

      StSetWr: begin
        if (old_color != color_l_q) begin
          ram_we          = 1'b1;
          ram_wdata       = color_l_q;
          valid_d[ptr_q]  = 1'b1;
          dirty_d[ptr_q]  = 1'b1;
        end
        state_d = StIdle;
      end

      StClear: begin
        if (old_color != '0) begin
          ram_we          = 1'b1;
          valid_d[ptr_q]  = 1'b1;
          dirty_d[ptr_q]  = 1'b1;
        end
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == led_idx_t'(LedCount - 1)) begin
          state_d = StIdle;
        end
      end

      StShow: begin
        // blank then draw folded into one write per led
        ram_we         = 1'b1;
        ram_wdata      = pix_new;
        valid_d[ptr_q] = 1'b1;
        if ((old_color != '0) || (pix_new != '0)) begin
          dirty_d[ptr_q] = 1'b1;
        end
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == led_idx_t'(LedCount - 1)) begin
          if (dirty_d != '0) begin
            state_d = StScan;
          end else if (pending_q) begin
            state_d = StLatch;
          end else begin
            state_d = StIdle;
          end
        end
      end

      StScan: begin
        if (dirty_q[ptr_q]) begin
          if (out_free) begin
            m_valid_d      = 1'b1;
            has_pixel_d    = 1'b1;
            out_index_d    = ptr_q;
            out_color_d    = old_color;
            latch_d        = last_dirty;
            dirty_d[ptr_q] = 1'b0;
            pending_d      = 1'b0;
            if (last_dirty) begin
              state_d = StIdle;
            end else begin
              ptr_d = ptr_q + 1'b1;
            end
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      StLatch: begin
        if (out_free) begin
          m_valid_d   = 1'b1;
          has_pixel_d = 1'b0;
          out_index_d = '0;
          out_color_d = '0;
          latch_d     = 1'b1;
          pending_d   = 1'b0;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ptr_q     <= '0;
      dirty_q   <= '0;
      valid_q   <= '0;
      pending_q <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      dirty_q   <= dirty_d;
      valid_q   <= valid_d;
      pending_q <= pending_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_l_q   <= color_l_d;
    color_r_q   <= color_r_d;
    dig_l_q     <= dig_l_d;
    dig_r_q     <= dig_r_d;
    center_q    <= center_d;
    has_pixel_q <= has_pixel_d;
    out_index_q <= out_index_d;
    out_color_q <= out_color_d;
    latch_q     <= latch_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_color_q, out_index_q};
  assign m_axis_tuser  = has_pixel_q;
  assign m_axis_tlast  = latch_q;

endmodule

// ===== rtl/core/lmdfb_checker.sv =====
// port-level checks for the led matrix frame buffer, bound to its top level
// depends on lmdfb_pkg and led_matrix_dirty_frame_buffer
module lmdfb_checker
  import lmdfb_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [SUserW-1:0] s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [MDataW-1:0] m_axis_tdata,
  input logic [MUserW-1:0] m_axis_tuser,
  input logic              m_axis_tlast
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // a beat without a pixel is the bare latch beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("beat without pixel is not a clean latch");

  // padding above the color stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[MDataW-1:30] == '0))
    else $error("result padding not zero");

  // set, clear and show commands keep the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != KindUpdate) &&
      (s_axis_tuser <= KindShowTwo) |=> !s_axis_tready)
    else $error("command beat taken without a busy cycle");

endmodule

bind led_matrix_dirty_frame_buffer lmdfb_checker u_lmdfb_checker (.*);

// ===== verif/led_matrix_dirty_frame_buffer_tb.sv =====
// self-checking bench for the led matrix frame buffer: directed and random commands
// depends on lmdfb_pkg and led_matrix_dirty_frame_buffer; predicts each strip beat itself
module led_matrix_dirty_frame_buffer_tb;
  import lmdfb_pkg::*;

  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;
  localparam int         RandCmds   = 145;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] col;
    logic [2:0] row;
    led_idx_t   idx;
    color_t     color_a;
    color_t     color_b;
    logic [6:0] number_a;
    logic [3:0] number_b;
  } cmd_t;

  typedef struct packed {
    logic     has_pixel;
    led_idx_t index;
    color_t   color;
    logic     latch;
  } led_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata = '0;
  logic [SUserW-1:0] s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MDataW-1:0] m_axis_tdata;
  logic [MUserW-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  led_matrix_dirty_frame_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // shadow copy of the frame store
  color_t shadow_color [LedCount];
  logic   shadow_dirty [LedCount];
  logic   shadow_refresh;

  cmd_t      cmd_queue[$];
  led_beat_t led_beats_due[$];
  int        cmd_total;
  int        cmds_offered = 0;
  int        cmds_taken = 0;
  int        beats_checked = 0;
  int        frames_latched = 0;
  int        mismatches = 0;
  cmd_t      next_cmd;
  cmd_t      taken_cmd;
  led_beat_t got_beat;
  led_beat_t exp_beat;

  // font rows top to bottom, row 0 in the top nibble; bit 3 is the left column
  function automatic logic [3:0] glyph_line(int digit, int r);
    logic [31:0] rows;
    case (digit)
      0:       rows = 32'hF999999F;
      1:       rows = 32'h26A2222F;
      2:       rows = 32'hF11F888F;
      3:       rows = 32'hF11F111F;
      4:       rows = 32'h999F1111;
      5:       rows = 32'hF88F111F;
      6:       rows = 32'hF88F999F;
      7:       rows = 32'hF1111111;
      8:       rows = 32'hF99F999F;
      9:       rows = 32'hF99F111F;
      default: rows = '0;
    endcase
    return rows[31 - 4 * r -: 4];
  endfunction

  function automatic led_idx_t strip_pos(int col, int row);
    return led_idx_t'(row * 8 + (((row % 2) != 0) ? col : LastCol - col));
  endfunction

  task automatic store_led(led_idx_t i, color_t c);
    if (shadow_color[i] != c) begin
      shadow_color[i] = c;
      shadow_dirty[i] = 1'b1;
    end
  endtask

  task automatic draw_glyph(int digit, int offset, color_t c);
    logic [3:0] line;
    if (digit > 9) return;
    for (int r = 0; r < 8; r++) begin
      line = glyph_line(digit, r);
      for (int k = 0; k < 4; k++)
        if (line[3 - k]) store_led(strip_pos(k + offset, r), c);
    end
  endtask

  task automatic blank_matrix();
    for (int i = 0; i < LedCount; i++) store_led(led_idx_t'(i), '0);
  endtask

  // the last dirty led carries the latch, so hold each beat until the next one shows up
  task automatic scan_strip();
    led_beat_t held;
    logic      have_held;
    have_held = 1'b0;
    for (int i = 0; i < LedCount; i++) begin
      if (shadow_dirty[i]) begin
        shadow_dirty[i] = 1'b0;
        if (have_held) led_beats_due.push_back(held);
        held = '{1'b1, led_idx_t'(i), shadow_color[i], 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.latch = 1'b1;
      led_beats_due.push_back(held);
      shadow_refresh = 1'b0;
    end else if (shadow_refresh) begin
      led_beats_due.push_back('{1'b0, '0, '0, 1'b1});
      shadow_refresh = 1'b0;
    end
  endtask

  task automatic apply_command(cmd_t c);
    case (c.kind)
      KindSetXy:  store_led(strip_pos(c.col, c.row), c.color_a);
      KindSetIdx: store_led(c.idx, c.color_a);
      KindClear:  blank_matrix();
      KindUpdate: scan_strip();
      KindShowNum: begin
        blank_matrix();
        if (c.number_a <= MaxNumber) begin
          if (c.number_a < Radix) begin
            draw_glyph(c.number_a, 2, c.color_a);
          end else begin
            draw_glyph(c.number_a / Radix, 0, c.color_a);
            draw_glyph(c.number_a % Radix, 4, c.color_a);
          end
        end
        scan_strip();
      end
      KindShowTwo: begin
        blank_matrix();
        draw_glyph(c.number_a, 0, c.color_a);
        draw_glyph(c.number_b, 4, c.color_b);
        scan_strip();
      end
      default: ;
    endcase
  endtask

  function automatic logic [SDataW-1:0] pack_cmd(cmd_t c);
    return {1'b0, c.number_b, c.number_a, c.color_b, c.color_a, c.idx, c.row, c.col};
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] kind, int col, int row, int idx,
                                    color_t ca, color_t cb, int na, int nb);
    cmd_t c;
    c.kind     = kind;
    c.col      = 3'(col);
    c.row      = 3'(row);
    c.idx      = led_idx_t'(idx);
    c.color_a  = ca;
    c.color_b  = cb;
    c.number_a = 7'(na);
    c.number_b = 4'(nb);
    return c;
  endfunction

  // a small palette makes repeated colors, and so unchanged writes, common
  function automatic color_t pick_color();
    color_t palette [4];
    palette = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h5A5A5A};
    if ($urandom_range(2) == 0) return palette[$urandom_range(3)];
    return color_t'($urandom());
  endfunction

  function automatic cmd_t rand_cmd(logic [2:0] kind);
    cmd_t c;
    c.kind     = kind;
    c.col      = 3'($urandom());
    c.row      = 3'($urandom());
    c.idx      = led_idx_t'($urandom());
    c.color_a  = pick_color();
    c.color_b  = pick_color();
    c.number_a = 7'($urandom());
    c.number_b = 4'($urandom());
    if (kind == KindShowNum && $urandom_range(3) != 0) c.number_a = 7'($urandom_range(99));
    if (kind == KindShowTwo && $urandom_range(3) != 0) begin
      c.number_a = 7'($urandom_range(9));
      c.number_b = 4'($urandom_range(9));
    end
    return c;
  endfunction

  // input driver: a new beat goes out only once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || cmds_taken == cmds_offered)) begin
      if (cmd_queue.size() != 0 &&
          ((cmds_offered >= 70 && cmds_offered < 110) || $urandom_range(99) >= 33)) begin
        next_cmd = cmd_queue.pop_front();
        s_axis_tdata  <= pack_cmd(next_cmd);
        s_axis_tuser  <= next_cmd.kind;
        s_axis_tvalid <= 1'b1;
        cmds_offered++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (cmds_taken >= 70 && cmds_taken < 110) || $urandom_range(99) >= 33;
  end

  // output beats are checked before a command taken in the same cycle is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_beat = '{m_axis_tuser[0], m_axis_tdata[5:0], m_axis_tdata[29:6], m_axis_tlast};
        beats_checked++;
        if (m_axis_tlast) frames_latched++;
        if (led_beats_due.size() == 0) begin
          $display("%0t: unexpected beat has_pixel=%0d index=%0d color=%06h latch=%0d",
                   $time, got_beat.has_pixel, got_beat.index, got_beat.color, got_beat.latch);
          mismatches++;
        end else begin
          exp_beat = led_beats_due.pop_front();
          if (got_beat !== exp_beat) begin
            $display("%0t: expected has_pixel=%0d index=%0d color=%06h latch=%0d", $time,
                     exp_beat.has_pixel, exp_beat.index, exp_beat.color, exp_beat.latch);
            $display("%0t: actual   has_pixel=%0d index=%0d color=%06h latch=%0d", $time,
                     got_beat.has_pixel, got_beat.index, got_beat.color, got_beat.latch);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_cmd = make_cmd(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[5:3],
                             s_axis_tdata[11:6], s_axis_tdata[35:12], s_axis_tdata[59:36],
                             s_axis_tdata[66:60], s_axis_tdata[70:67]);
        apply_command(taken_cmd);
        cmds_taken++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats still due", led_beats_due.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int   n;
    int   burst;
    int   pick;
    for (int i = 0; i < LedCount; i++) begin
      shadow_color[i] = '0;
      shadow_dirty[i] = 1'b0;
    end
    shadow_refresh = 1'b1;

    // refresh pending from reset, then an update with nothing to do
    cmd_queue.push_back(make_cmd(KindUpdate, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindUpdate, 7, 7, 63, 24'hFFFFFF, 24'hFFFFFF, 127, 15));
    cmd_queue.push_back(make_cmd(KindSetXy, 0, 0, 0, 24'hFFFFFF, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetXy, 7, 7, 0, 24'h000001, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetXy, 5, 2, 0, 24'h800000, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetIdx, 0, 0, 63, 24'hFFFFFF, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetIdx, 0, 0, 0, 24'h123456, 0, 0, 0));
    // same color again leaves the store and the dirty bit as they were
    cmd_queue.push_back(make_cmd(KindSetIdx, 0, 0, 63, 24'hFFFFFF, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindUpdate, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetXy, 0, 0, 0, 24'h000000, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSetXy, 0, 1, 0, 24'h000000, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindUpdate, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindSpare6, 3, 3, 9, 24'hABCDEF, 24'h1, 5, 5));
    cmd_queue.push_back(make_cmd(KindSpare7, 1, 1, 1, 24'h1, 24'h1, 1, 1));
    cmd_queue.push_back(make_cmd(KindClear, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindUpdate, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'h00FF00, 0, 7, 0));
    // blanked and redrawn with the old color still goes out
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'h00FF00, 0, 7, 0));
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'h0000FF, 0, 42, 0));
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'hFFFFFF, 0, 99, 0));
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'hFFFFFF, 0, 100, 0));
    cmd_queue.push_back(make_cmd(KindShowTwo, 0, 0, 0, 24'hFF0000, 24'h0000FF, 9, 0));
    cmd_queue.push_back(make_cmd(KindShowTwo, 0, 0, 0, 24'hFF0000, 24'h0000FF, 12, 15));
    cmd_queue.push_back(make_cmd(KindShowTwo, 0, 0, 0, 24'h00FF00, 24'hFFFFFF, 127, 8));
    cmd_queue.push_back(make_cmd(KindShowNum, 0, 0, 0, 24'hFFFFFF, 0, 127, 0));

    // mostly bursts of writes closed by an update, the rest single commands
    n = 0;
    while (n < RandCmds) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        burst = $urandom_range(6, 1);
        repeat (burst)
          cmd_queue.push_back(rand_cmd(($urandom_range(1) != 0) ? KindSetXy : KindSetIdx));
        cmd_queue.push_back(rand_cmd(KindUpdate));
        n += burst + 1;
      end else begin
        if (pick < 75)      cmd_queue.push_back(rand_cmd(KindShowNum));
        else if (pick < 88) cmd_queue.push_back(rand_cmd(KindShowTwo));
        else if (pick < 93) cmd_queue.push_back(rand_cmd(KindClear));
        else if (pick < 97) cmd_queue.push_back(rand_cmd(KindUpdate));
        else cmd_queue.push_back(rand_cmd(($urandom_range(1) != 0) ? KindSpare6 : KindSpare7));
        if (pick < 97) n++;
      end
    end
    cmd_total = cmd_queue.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmds_taken != cmd_total) @(posedge clk_i);
    while (led_beats_due.size() != 0) @(posedge clk_i);
    // a trailing show or write may still be busy; any beat from it would be unexpected
    repeat (300) @(posedge clk_i);
    if (led_beats_due.size() != 0) begin
      $display("%0t: %0d beats expected but never seen", $time, led_beats_due.size());
      mismatches++;
    end

    $display("%0d commands driven, %0d strip beats checked, %0d frames latched",
             cmds_taken, beats_checked, frames_latched);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== led_matrix_dirty_frame_buffer.f =====
rtl/core/lmdfb_pkg.sv
rtl/core/lmdfb_ram.sv
rtl/core/led_matrix_dirty_frame_buffer.sv
rtl/core/lmdfb_checker.sv
verif/led_matrix_dirty_frame_buffer_tb.sv
